[rtl/core/flow_session_tracker_defines.svh]
// Assertion macros for the flow session tracker checker.
// Depends on nothing; included by the checker file only.
`ifndef FLOW_SESSION_TRACKER_DEFINES_SVH
`define FLOW_SESSION_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/fst_pkg.sv]
// Shared widths, codes and pipeline types of the flow session tracker.
// Depends on nothing; imported by the tracker and its checker.
package fst_pkg;

  localparam int RATE_W       = 20;
  localparam int WORD_W       = 32;
  localparam int LEAK_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 23;
  localparam int TIMEOUT_MS_W = 33;
  localparam int MS_PER_S     = 1000;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  localparam logic [TIMEOUT_MS_W-1:0] TIMEOUT_MS_RESET = 33'd90000;
  localparam logic [RATE_W-1:0]       THRESHOLD_RESET  = 20'd500;
  localparam logic [RATE_W-1:0]       LEAK_MIN         = 20'd1;

  // x / 1000 == (x * DIV1000_MAGIC) >> DIV1000_SHIFT, exact for every 32-bit x.
  localparam logic [WORD_W-1:0] DIV1000_MAGIC = 32'd274877907;
  localparam int                DIV1000_SHIFT = 38;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_ACTIVE = 3'b010,
    PH_ENDING = 3'b100
  } phase_e;

  // Result as it leaves the session logic, before the divide.
  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] number;
    logic [WORD_W-1:0] start_s;
    logic [WORD_W-1:0] end_s;
    logic [WORD_W-1:0] dur;
    logic [WORD_W-1:0] flow_ms;
    logic [WORD_W-1:0] vol_out;
    logic [WORD_W-1:0] vol_in;
    logic [RATE_W-1:0] max_out;
    logic [RATE_W-1:0] peak_in;
    logic [LEAK_W-1:0] leak;
  } s1_t;

  // Result after the divide, flow time in seconds.
  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] number;
    logic [WORD_W-1:0] start_s;
    logic [WORD_W-1:0] end_s;
    logic [WORD_W-1:0] dur;
    logic [WORD_W-1:0] fts;
    logic [WORD_W-1:0] vol_out;
    logic [WORD_W-1:0] vol_in;
    logic [RATE_W-1:0] max_out;
    logic [RATE_W-1:0] peak_in;
    logic [LEAK_W-1:0] leak;
  } s2_t;

endpackage

[rtl/core/flow_session_tracker.sv]
// Flow session tracker: session state machine and a three-stage result pipeline.
// Depends on fst_pkg.

// The tracker takes one sample per cycle while in_ready_o is high and returns exactly
// one result word per sample, valid on out_valid_o once it has passed the s1, s2 and
// out registers. The session state (phase, start snapshot, peaks, flow time) is
// updated in the cycle a sample is accepted, so consecutive samples need no gap. The
// result then passes a stage that multiplies the accumulated flow milliseconds by a
// reciprocal of 1000 to give the flow time in seconds, and a final stage that forms
// the idle time. Backpressure from the output propagates through the pipeline valid
// bits to in_ready_o. Configuration writes take effect at once and must only be
// issued while no sample is in flight; clearing enable drops an open session.
module flow_session_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fst_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fst_pkg::RATE_W-1:0]     rate_out_i,
  input  logic [fst_pkg::RATE_W-1:0]     rate_in_i,
  input  logic [fst_pkg::WORD_W-1:0]     total_out_i,
  input  logic [fst_pkg::WORD_W-1:0]     total_in_i,
  input  logic [fst_pkg::WORD_W-1:0]     now_ms_i,
  input  logic [fst_pkg::WORD_W-1:0]     now_s_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           session_done_o,
  output logic [fst_pkg::WORD_W-1:0]     session_number_o,
  output logic [fst_pkg::WORD_W-1:0]     start_time_o,
  output logic [fst_pkg::WORD_W-1:0]     end_time_o,
  output logic [fst_pkg::WORD_W-1:0]     sess_dur_o,
  output logic [fst_pkg::WORD_W-1:0]     flow_time_s_o,
  output logic [fst_pkg::WORD_W-1:0]     idle_secs_o,
  output logic [fst_pkg::WORD_W-1:0]     volume_out_o,
  output logic [fst_pkg::WORD_W-1:0]     volume_in_o,
  output logic [fst_pkg::RATE_W-1:0]     max_out_o,
  output logic [fst_pkg::RATE_W-1:0]     peak_in_o,
  output logic [fst_pkg::LEAK_W-1:0]     leak_flags_o
);
  import fst_pkg::*;

  // Configuration.
  logic                    enable_q;
  logic [TIMEOUT_MS_W-1:0] timeout_ms_q;
  logic [RATE_W-1:0]       thr_q;

  // Session state.
  phase_e            phase_q, phase_d;
  logic [WORD_W-1:0] counter_q, counter_d;
  logic [WORD_W-1:0] start_s_q, start_s_d;
  logic [WORD_W-1:0] start_out_q, start_out_d;
  logic [WORD_W-1:0] start_in_q, start_in_d;
  logic [RATE_W-1:0] max_out_q, max_out_d;
  logic [RATE_W-1:0] peak_in_q, peak_in_d;
  logic [WORD_W-1:0] seg_ms_q, seg_ms_d;
  logic [WORD_W-1:0] flow_ms_q, flow_ms_d;
  logic [WORD_W-1:0] end_ms_q, end_ms_d;

  // Pipeline.
  logic              s1_v_q, s2_v_q, out_v_q;
  s1_t               s1_q, s1_d;
  s2_t               s2_q, out_q;
  logic [WORD_W-1:0] out_idle_q;
  logic [2*WORD_W-1:0] prod;
  logic              out_load, s2_load, s1_load, accept;

  logic              flow, done, cfg_off;
  logic [WORD_W-1:0] elapsed_ms;

  assign out_load   = !out_v_q || out_ready_i;
  assign s2_load    = !s2_v_q || out_load;
  assign s1_load    = !s1_v_q || s2_load;
  assign in_ready_o = s1_load;
  assign accept     = in_valid_i && s1_load;

  assign flow       = (rate_out_i > thr_q) || (rate_in_i > thr_q);
  assign elapsed_ms = now_ms_i - end_ms_q;
  assign cfg_off    = cfg_we_i && (cfg_idx_i == CFG_ENABLE) && !cfg_wdata_i[0];

  always_comb begin
    phase_d     = phase_q;
    counter_d   = counter_q;
    start_s_d   = start_s_q;
    start_out_d = start_out_q;
    start_in_d  = start_in_q;
    max_out_d   = max_out_q;
    peak_in_d   = peak_in_q;
    seg_ms_d    = seg_ms_q;
    flow_ms_d   = flow_ms_q;
    end_ms_d    = end_ms_q;
    done        = 1'b0;
    if (!enable_q) begin
      phase_d = PH_IDLE;
    end else begin
      unique case (phase_q)
        PH_ACTIVE: begin
          if (rate_out_i > max_out_q) max_out_d = rate_out_i;
          if (rate_in_i > peak_in_q) peak_in_d = rate_in_i;
          if (!flow) begin
            flow_ms_d = flow_ms_q + (now_ms_i - seg_ms_q);
            end_ms_d  = now_ms_i;
            phase_d   = PH_ENDING;
          end
        end
        PH_ENDING: begin
          if (flow) begin
            seg_ms_d = now_ms_i;
            phase_d  = PH_ACTIVE;
            if (rate_out_i > max_out_q) max_out_d = rate_out_i;
            if (rate_in_i > peak_in_q) peak_in_d = rate_in_i;
          end else if ({1'b0, elapsed_ms} >= timeout_ms_q) begin
            done      = 1'b1;
            counter_d = counter_q + 32'd1;
            phase_d   = PH_IDLE;
          end
        end
        default: begin
          if (flow) begin
            phase_d     = PH_ACTIVE;
            start_s_d   = now_s_i;
            start_out_d = total_out_i;
            start_in_d  = total_in_i;
            max_out_d   = rate_out_i;
            peak_in_d   = rate_in_i;
            flow_ms_d   = '0;
            seg_ms_d    = now_ms_i;
          end
        end
      endcase
    end
  end

  // Session fields come from the state before this sample; all zero unless it closed.
  always_comb begin
    s1_d = '0;
    if (done) begin
      s1_d.done     = 1'b1;
      s1_d.number   = counter_q;
      s1_d.start_s  = start_s_q;
      s1_d.end_s    = now_s_i;
      s1_d.dur      = (now_s_i > start_s_q) ? now_s_i - start_s_q : '0;
      s1_d.flow_ms  = flow_ms_q;
      s1_d.vol_out  = (total_out_i > start_out_q) ? total_out_i - start_out_q : '0;
      s1_d.vol_in   = (total_in_i > start_in_q) ? total_in_i - start_in_q : '0;
      s1_d.max_out  = max_out_q;
      s1_d.peak_in  = peak_in_q;
    end
    if (phase_d == PH_IDLE) begin
      s1_d.leak[0] = (rate_out_i > LEAK_MIN) && (rate_out_i < thr_q);
      s1_d.leak[1] = (rate_in_i > LEAK_MIN) && (rate_in_i < thr_q);
    end
  end

  assign prod = {{WORD_W{1'b0}}, s1_q.flow_ms} * {{WORD_W{1'b0}}, DIV1000_MAGIC};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b1;
      timeout_ms_q <= TIMEOUT_MS_RESET;
      thr_q        <= THRESHOLD_RESET;
      phase_q      <= PH_IDLE;
      counter_q    <= '0;
      start_s_q    <= '0;
      start_out_q  <= '0;
      start_in_q   <= '0;
      max_out_q    <= '0;
      peak_in_q    <= '0;
      seg_ms_q     <= '0;
      flow_ms_q    <= '0;
      end_ms_q     <= '0;
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      // Clearing enable forces idle and takes precedence over a sample.
      if (cfg_off) begin
        phase_q <= PH_IDLE;
      end else if (accept) begin
        phase_q <= phase_d;
      end
      if (accept) begin
        counter_q   <= counter_d;
        start_s_q   <= start_s_d;
        start_out_q <= start_out_d;
        start_in_q  <= start_in_d;
        max_out_q   <= max_out_d;
        peak_in_q   <= peak_in_d;
        seg_ms_q    <= seg_ms_d;
        flow_ms_q   <= flow_ms_d;
        end_ms_q    <= end_ms_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ENABLE: begin
            enable_q <= cfg_wdata_i[0];
          end
          CFG_TIMEOUT: begin
            timeout_ms_q <= TIMEOUT_MS_W'(cfg_wdata_i) * TIMEOUT_MS_W'(MS_PER_S);
          end
          CFG_THRESHOLD: begin
            thr_q <= cfg_wdata_i[RATE_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (s1_load) s1_v_q <= in_valid_i;
      if (s2_load) s2_v_q <= s1_v_q;
      if (out_load) out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) s1_q <= s1_d;
    if (s2_load) begin
      s2_q.done     <= s1_q.done;
      s2_q.number   <= s1_q.number;
      s2_q.start_s  <= s1_q.start_s;
      s2_q.end_s    <= s1_q.end_s;
      s2_q.dur      <= s1_q.dur;
      s2_q.fts      <= WORD_W'(prod >> DIV1000_SHIFT);
      s2_q.vol_out  <= s1_q.vol_out;
      s2_q.vol_in   <= s1_q.vol_in;
      s2_q.max_out  <= s1_q.max_out;
      s2_q.peak_in  <= s1_q.peak_in;
      s2_q.leak     <= s1_q.leak;
    end
    if (out_load) begin
      out_q      <= s2_q;
      out_idle_q <= (s2_q.dur > s2_q.fts) ? s2_q.dur - s2_q.fts : '0;
    end
  end

  assign out_valid_o      = out_v_q;
  assign session_done_o   = out_q.done;
  assign session_number_o = out_q.number;
  assign start_time_o     = out_q.start_s;
  assign end_time_o       = out_q.end_s;
  assign sess_dur_o       = out_q.dur;
  assign flow_time_s_o    = out_q.fts;
  assign idle_secs_o      = out_idle_q;
  assign volume_out_o     = out_q.vol_out;
  assign volume_in_o      = out_q.vol_in;
  assign max_out_o        = out_q.max_out;
  assign peak_in_o        = out_q.peak_in;
  assign leak_flags_o     = out_q.leak;

endmodule

[rtl/core/fst_checker.sv]
// Port-level checker for the flow session tracker, bound to its top level.
// Depends on fst_pkg and flow_session_tracker_defines.svh.
`include "flow_session_tracker_defines.svh"

module fst_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           session_done_o,
  input logic [fst_pkg::WORD_W-1:0]     session_number_o,
  input logic [fst_pkg::WORD_W-1:0]     start_time_o,
  input logic [fst_pkg::WORD_W-1:0]     end_time_o,
  input logic [fst_pkg::WORD_W-1:0]     sess_dur_o,
  input logic [fst_pkg::WORD_W-1:0]     flow_time_s_o,
  input logic [fst_pkg::WORD_W-1:0]     idle_secs_o,
  input logic [fst_pkg::WORD_W-1:0]     volume_out_o,
  input logic [fst_pkg::RATE_W-1:0]     max_out_o,
  input logic [fst_pkg::LEAK_W-1:0]     leak_flags_o
);
  import fst_pkg::*;

  logic              seen_q;
  logic [WORD_W-1:0] last_num_q;
  logic              out_take;

  assign out_take = out_valid_o && out_ready_i;

  // Remembers the id of the last closed session that left the block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_num_q <= '0;
    end else if (out_take && session_done_o) begin
      seen_q     <= 1'b1;
      last_num_q <= session_number_o;
    end
  end

  `FST_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(session_done_o) && $stable(session_number_o) && $stable(leak_flags_o), "result changed while stalled")

  `FST_ASSERT_IMP(a_quiet_fields, clk_i, rst_ni, out_valid_o && !session_done_o, session_number_o == '0 && sess_dur_o == '0 && flow_time_s_o == '0 && idle_secs_o == '0 && volume_out_o == '0 && max_out_o == '0, "session fields set without a closed session")

  `FST_ASSERT_IMP(a_times, clk_i, rst_ni, out_valid_o && session_done_o, sess_dur_o == ((end_time_o > start_time_o) ? end_time_o - start_time_o : '0) && idle_secs_o <= sess_dur_o, "session times inconsistent")

  `FST_ASSERT_IMP(a_id_seq, clk_i, rst_ni, out_take && session_done_o && seen_q, session_number_o == WORD_W'(last_num_q + 32'd1), "session ids not consecutive")

endmodule

bind flow_session_tracker fst_checker u_fst_checker (.*);
